// ===== sv/okl_pkg.sv =====
package okl_pkg;

  // Default list size and fixed field widths.
  localparam int OKL_CAPACITY    = 16;
  localparam int OKL_DATA_W      = 16;
  localparam int OKL_OP_W        = 2;
  localparam int OKL_COUNT_OUT_W = 5;

  // Request codes.
  typedef enum logic [OKL_OP_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REMOVE    = 2'd2,
    OP_SEARCH    = 2'd3
  } okl_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } okl_state_t;

  // Per-cell update command; at most one bit is set.
  typedef struct packed {
    logic load;        // take the request entry
    logic from_left;   // take the entry of the cell one position lower
    logic from_right;  // take the entry of the cell one position higher
  } okl_cell_ctl_t;

endpackage

// ===== sv/okl_if.sv =====
// Request channel: one transaction carries one list request.
interface okl_in_if import okl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OKL_OP_W-1:0]   opcode;
  logic [OKL_DATA_W-1:0] key;
  logic [OKL_DATA_W-1:0] payload;

  modport source (output valid, output opcode, output key, output payload, input ready);
  modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

// Result channel: one transaction carries the outcome of one request.
interface okl_out_if import okl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [OKL_DATA_W-1:0]      found_payload;
  logic [OKL_COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output ok, output found_payload, output entry_count,
                  input ready);
  modport sink   (input valid, input ok, input found_payload, input entry_count,
                  output ready);
endinterface

// ===== sv/okl_cell.sv =====
module okl_cell import okl_pkg::*; (
  input  logic                  clk,
  input  okl_cell_ctl_t         ctl,
  input  logic                  occupied,
  input  logic [OKL_DATA_W-1:0] req_key,
  input  logic [OKL_DATA_W-1:0] req_payload,
  input  logic [OKL_DATA_W-1:0] left_key,
  input  logic [OKL_DATA_W-1:0] left_payload,
  input  logic [OKL_DATA_W-1:0] right_key,
  input  logic [OKL_DATA_W-1:0] right_payload,
  output logic [OKL_DATA_W-1:0] key,
  output logic [OKL_DATA_W-1:0] payload,
  output logic                  match
);

  logic [OKL_DATA_W-1:0] key_r;
  logic [OKL_DATA_W-1:0] payload_r;
  logic                  match_r;

  // Entry storage: load a new entry or shift from a neighbor, otherwise hold.
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      key_r     <= req_key;
      payload_r <= req_payload;
    end else if (ctl.from_left) begin
      key_r     <= left_key;
      payload_r <= left_payload;
    end else if (ctl.from_right) begin
      key_r     <= right_key;
      payload_r <= right_payload;
    end else begin
      key_r     <= key_r;
      payload_r <= payload_r;
    end
  end

  // Key compare against the pending request, registered for the update cycle.
  always_ff @(posedge clk) begin
    match_r <= occupied && (key_r == req_key);
  end

  assign key     = key_r;
  assign payload = payload_r;
  assign match   = match_r;

endmodule

// ===== sv/ordered_key_list_unit.sv =====
// Bounded ordered list of up to CAPACITY key/payload entries, held in a row of
// cells with position 0 at the front. A request inserts at the front or back,
// removes the first entry whose key matches, or looks up the first match and
// returns its payload; every result also reports the entry count after the
// request. One request is in work at a time, in a match state and then an
// apply state: first every cell compares its key with the request key, then
// the cells shift by one position to open or close a gap where needed and the
// result is registered. A new request is taken as the apply state completes,
// not before, and the apply state waits while the result slot is full. An
// insert into a full list and a remove or search without a match return ok
// low and change nothing.
module ordered_key_list_unit import okl_pkg::*; #(
  parameter int CAPACITY = OKL_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  okl_in_if.sink     in_ch,
  okl_out_if.source  out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  okl_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;

  okl_op_t               req_op_r;
  logic [OKL_DATA_W-1:0] req_key_r;
  logic [OKL_DATA_W-1:0] req_payload_r;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r;
  logic [OKL_DATA_W-1:0]      out_found_r;
  logic [OKL_COUNT_OUT_W-1:0] out_count_r;

  logic [OKL_DATA_W-1:0] cell_key     [CAPACITY];
  logic [OKL_DATA_W-1:0] cell_payload [CAPACITY];
  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   hit_le;
  logic [CAPACITY-1:0]   first;
  okl_cell_ctl_t         cell_ctl [CAPACITY];

  logic                  apply_go;
  logic                  accept;
  logic                  not_full;
  logic                  any_hit;
  logic                  res_ok;
  logic [OKL_DATA_W-1:0] res_found;

  // Handshake: a result slot is free when empty or drained this cycle.
  assign apply_go     = (state_r == ST_APPLY) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = (state_r == ST_IDLE) || apply_go;
  assign accept       = in_ch.valid && in_ch.ready;
  assign not_full     = count_r < CW'(CAPACITY);
  assign any_hit      = |match;

  // Row of cells with per-position shift control and first-match detection.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [OKL_DATA_W-1:0] left_key, left_payload, right_key, right_payload;

    assign hit_le[i] = |match[i:0];

    if (i == 0) begin : g_front
      assign first[i]     = match[i];
      assign left_key     = req_key_r;
      assign left_payload = req_payload_r;
    end else begin : g_inner
      assign first[i]     = match[i] && !hit_le[i-1];
      assign left_key     = cell_key[i-1];
      assign left_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_key     = cell_key[i];
      assign right_payload = cell_payload[i];
    end else begin : g_mid
      assign right_key     = cell_key[i+1];
      assign right_payload = cell_payload[i+1];
    end

    always_comb begin
      cell_ctl[i] = '0;
      if (apply_go) begin
        unique case (req_op_r)
          OP_INS_FRONT: begin
            cell_ctl[i].load      = not_full && (i == 0);
            cell_ctl[i].from_left = not_full && (i != 0);
          end
          OP_INS_BACK: begin
            cell_ctl[i].load = not_full && (count_r == CW'(i));
          end
          OP_REMOVE: begin
            cell_ctl[i].from_right = hit_le[i];
          end
          OP_SEARCH: begin
            cell_ctl[i] = '0;
          end
          default: begin
            cell_ctl[i] = '0;
          end
        endcase
      end
    end

    okl_cell u_cell (
      .clk           (clk),
      .ctl           (cell_ctl[i]),
      .occupied      (count_r > CW'(i)),
      .req_key       (req_key_r),
      .req_payload   (req_payload_r),
      .left_key      (left_key),
      .left_payload  (left_payload),
      .right_key     (right_key),
      .right_payload (right_payload),
      .key           (cell_key[i]),
      .payload       (cell_payload[i]),
      .match         (match[i])
    );
  end

  // Payload of the first matching cell, one-hot AND-OR select.
  always_comb begin
    res_found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      res_found = res_found | (cell_payload[i] & {OKL_DATA_W{first[i]}});
    end
  end

  // Outcome and count update of the request in its update cycle.
  always_comb begin
    count_nxt = count_r;
    res_ok    = 1'b0;
    unique case (req_op_r)
      OP_INS_FRONT, OP_INS_BACK: begin
        res_ok = not_full;
        if (apply_go && not_full) begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        res_ok = any_hit;
        if (apply_go && any_hit) begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_SEARCH: begin
        res_ok = any_hit;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (accept) begin
          state_nxt = ST_MATCH;
        end else if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result slot occupancy.
  always_comb begin
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pending request capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r      <= okl_op_t'(in_ch.opcode);
      req_key_r     <= in_ch.key;
      req_payload_r <= in_ch.payload;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_ok_r    <= res_ok;
      out_found_r <= (req_op_r == OP_SEARCH && any_hit) ? res_found : '0;
      out_count_r <= OKL_COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.found_payload = out_found_r;
  assign out_ch.entry_count   = out_count_r;

endmodule

// ===== sim/tb_ordered_key_list_unit.sv =====
`timescale 1ns / 1ps

module tb_ordered_key_list_unit import okl_pkg::*;;

  localparam int MAX_WAIT     = 18;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int SEGMENT_LEN  = 50;
  localparam int TAIL_CYCLES  = 8;

  typedef logic [OKL_DATA_W-1:0] word_t;

  typedef struct {
    word_t key;
    word_t payload;
  } list_entry_t;

  typedef struct {
    logic                       ok;
    word_t                      found_payload;
    logic [OKL_COUNT_OUT_W-1:0] entry_count;
  } list_outcome_t;

  // Shadow copy of the list and the queue of outcomes still owed by the block.
  class okl_list_scoreboard;
    list_entry_t   entries[$];
    list_outcome_t outcomes[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    // Apply one accepted request to the shadow list and queue its outcome.
    function void note_request(okl_op_t op, word_t k, word_t pl);
      list_outcome_t res;
      list_entry_t   ent;
      int            pos;
      res.ok = 1'b0;
      res.found_payload = '0;
      ent.key = k;
      ent.payload = pl;
      pos = -1;
      for (int i = 0; i < entries.size() && pos < 0; i++) begin
        if (entries[i].key == k) pos = i;
      end
      case (op)
        OP_INS_FRONT: begin
          if (entries.size() < OKL_CAPACITY) begin
            entries.push_front(ent);
            res.ok = 1'b1;
          end
        end
        OP_INS_BACK: begin
          if (entries.size() < OKL_CAPACITY) begin
            entries.push_back(ent);
            res.ok = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pos >= 0) begin
            entries.delete(pos);
            res.ok = 1'b1;
          end
        end
        default: begin
          if (pos >= 0) begin
            res.found_payload = entries[pos].payload;
            res.ok = 1'b1;
          end
        end
      endcase
      res.entry_count = OKL_COUNT_OUT_W'(entries.size());
      outcomes.push_back(res);
    endfunction

    // Compare one accepted result with the oldest outstanding outcome.
    function void check_result(logic ok, word_t found, logic [OKL_COUNT_OUT_W-1:0] cnt);
      list_outcome_t exp;
      if (outcomes.size() == 0) begin
        $display("%0t: unexpected result ok=%0b found_payload=%h entry_count=%0d",
                 $time, ok, found, cnt);
        errors++;
        return;
      end
      exp = outcomes.pop_front();
      if (ok !== exp.ok) begin
        $display("%0t: ok mismatch, expected %0b, actual %0b", $time, exp.ok, ok);
        errors++;
      end
      if (found !== exp.found_payload) begin
        $display("%0t: found_payload mismatch, expected %h, actual %h",
                 $time, exp.found_payload, found);
        errors++;
      end
      if (cnt !== exp.entry_count) begin
        $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                 $time, exp.entry_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycle_count = 0;

  okl_list_scoreboard sb = new();

  okl_in_if  in_ch();
  okl_out_if out_ch();

  ordered_key_list_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one request, wait for its transaction, then record it.
  task automatic drive_request(okl_op_t op, word_t k, word_t pl);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.key     <= k;
    in_ch.payload <= pl;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, k, pl);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outcomes.size() != 0);
  endtask

  // Keys mostly come from a small pool or from the list itself so that
  // removes and searches hit often; the rest are fully random.
  function automatic word_t pick_key(bit match_list);
    word_t k;
    if (match_list && sb.entries.size() != 0 && $urandom_range(0, 1) == 1) begin
      k = sb.entries[$urandom_range(0, sb.entries.size() - 1)].key;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: k = word_t'($urandom_range(0, 5));
        6:                k = 16'hFFFF;
        default:          k = word_t'($urandom);
      endcase
    end
    return k;
  endfunction

  // Result side: random stalls on ready, check every transaction.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.ok, out_ch.found_payload, out_ch.entry_count);
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int      ins_pct;
    int      r;
    okl_op_t op;
    word_t   k;

    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_INS_FRONT;
    in_ch.key     <= '0;
    in_ch.payload <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list misses, extreme values, duplicates, fill to full.
    drive_request(OP_SEARCH, 16'h0000, 16'h0000);
    drive_request(OP_REMOVE, 16'h0000, 16'hFFFF);
    drive_request(OP_INS_BACK, 16'h0000, 16'h0000);
    drive_request(OP_INS_FRONT, 16'hFFFF, 16'hFFFF);
    drive_request(OP_INS_BACK, 16'hFFFF, 16'h1234);
    drive_request(OP_SEARCH, 16'hFFFF, 16'h0000);
    drive_request(OP_REMOVE, 16'hFFFF, 16'h0000);
    drive_request(OP_SEARCH, 16'hFFFF, 16'h0000);
    drive_request(OP_SEARCH, 16'h0000, 16'h5A5A);
    while (sb.entries.size() < OKL_CAPACITY) begin
      drive_request(sb.entries.size() % 2 ? OP_INS_FRONT : OP_INS_BACK,
                    word_t'(16'h8000 | sb.entries.size()), word_t'($urandom));
    end
    drive_request(OP_INS_FRONT, 16'hAAAA, 16'h5555);
    drive_request(OP_INS_BACK, 16'h5555, 16'hAAAA);
    drive_request(OP_REMOVE, 16'h0000, 16'h0000);
    drive_request(OP_SEARCH, 16'h1234, 16'h0000);
    drain_results();

    // Random segments alternate between filling, draining and mixed traffic,
    // some with no idling on either side.
    for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_LEN; seg++) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 70;
        1:       ins_pct = 20;
        default: ins_pct = 45;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < SEGMENT_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
          op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
          k  = pick_key(1'b0);
        end else begin
          op = $urandom_range(0, 1) ? OP_REMOVE : OP_SEARCH;
          k  = pick_key(1'b1);
        end
        drive_request(op, k, word_t'($urandom));
      end
      if (seg == 10) drain_results();
    end

    // Let every result come back, then a short quiet tail.
    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outcomes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
